// File: rtl/core/polyphonic_wavetable_mixer_macros.svh
// Assertion macros for the polyphonic wavetable mixer.
// Included by the modules that carry concurrent checks; needs clock and reset in scope.
`ifndef POLYPHONIC_WAVETABLE_MIXER_MACROS_SVH
`define POLYPHONIC_WAVETABLE_MIXER_MACROS_SVH

// same-cycle implication
`define PWTM_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PWTM_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pwtm_pkg.sv
// Shared types and constants for the polyphonic wavetable mixer.
// No dependencies.
package pwtm_pkg;

   localparam int VOICE_COUNT_DEF = 8;
   localparam int TABLE_DEPTH     = 256;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2,
      ACT_WRITE = 2'd3
   } action_type;

   // one voice memory word
   typedef struct packed {
      logic [15:0] phase;
      logic [15:0] step;
      logic [7:0]  gain;
   } voice_word_type;

   localparam logic [7:0] DAC_OFFSET = 8'd127;

endpackage

// File: rtl/core/polyphonic_wavetable_mixer.sv
// Polyphonic wavetable mixer: voice state and wavetable in two synchronous memories.
// A sample tick walks the voices one per cycle through the voice memory and the
// wavetable to the result register, and no item is taken before that. Start reads and
// writes back its voice entry; stop and a table write end in idle. The voice memory
// read port, one voice per cycle, sets the tick length. A finished sample waits in the
// result register while the next item is taken; a second sample waits until the first
// has gone. Uses pwtm_pkg and polyphonic_wavetable_mixer_macros.svh.
`include "polyphonic_wavetable_mixer_macros.svh"

module polyphonic_wavetable_mixer #(
   parameter int VOICE_COUNT = pwtm_pkg::VOICE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [2:0]        req_voice_index,
   input  logic [15:0]       req_step_value,
   input  logic [7:0]        req_gain_value,
   input  logic signed [7:0] req_vibrato_amount,
   input  logic signed [7:0] req_tremolo_amount,
   input  logic [7:0]        req_table_index,
   input  logic signed [7:0] req_table_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_dac_value
);

   localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int IW = ((VW > 3) ? VW : 3) + 1;
   localparam logic [VW-1:0] LAST_VOICE = VW'(VOICE_COUNT - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_TICK  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // memories
   pwtm_pkg::voice_word_type vmem [VOICE_COUNT];
   pwtm_pkg::voice_word_type vmem_rd_ff;
   logic [7:0]               wave_mem [pwtm_pkg::TABLE_DEPTH];
   logic [7:0]               wave_rd_ff;

   logic                     vmem_re, vmem_we;
   logic [VW-1:0]            vmem_raddr, vmem_waddr;
   pwtm_pkg::voice_word_type vmem_wdata;
   logic                     wave_re;
   logic [7:0]               wave_raddr;

   // voice flags
   logic [VOICE_COUNT-1:0] active_ff, active_in;
   logic [VOICE_COUNT-1:0] phase_vld_ff, phase_vld_in;

   // sequencer
   logic [VW-1:0] cnt_ff, cnt_in;
   logic [7:0]    vib_ff, vib_in;
   logic [7:0]    trem_ff, trem_in;
   logic [VW-1:0] st_idx_ff, st_idx_in;
   logic [15:0]   st_step_ff, st_step_in;
   logic [7:0]    st_gain_ff, st_gain_in;

   // voice pipeline
   logic          p1_vld_ff, p1_vld_in, p1_last_ff, p1_last_in;
   logic [VW-1:0] p1_idx_ff, p1_idx_in;
   logic          p2_vld_ff, p2_vld_in, p2_last_ff, p2_last_in, p2_act_ff, p2_act_in;
   logic [7:0]    p2_gain_ff, p2_gain_in;
   logic          p3_vld_ff, p3_vld_in, p3_last_ff, p3_last_in, p3_act_ff, p3_act_in;
   logic [7:0]    p3_q_ff, p3_q_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    hold_ff, hold_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_dac_ff, rsp_dac_in;

   logic                 req_acc, slot_free, out_load;
   pwtm_pkg::action_type act_code;
   logic [IW-1:0]        vi_ext;
   logic [VW-1:0]        vi_addr;
   logic                 vi_ok;
   logic                 b_act;
   logic [15:0]          b_phase, b_vib16;
   logic signed [5:0]    c_smp;
   logic signed [11:0]   c_gain;
   logic signed [17:0]   c_prod;
   logic [7:0]           d_sum, d_dac;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_acc       = req_valid && !req_stall;
   assign act_code      = pwtm_pkg::action_type'(req_action);
   assign vi_ext        = IW'(req_voice_index);
   assign vi_addr       = vi_ext[VW-1:0];
   assign vi_ok         = (vi_ext < IW'(VOICE_COUNT));
   assign slot_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dac_value = rsp_dac_ff;

   // stage B: voice word in hand
   assign b_act   = p1_vld_ff && active_ff[p1_idx_ff];
   assign b_phase = phase_vld_ff[p1_idx_ff] ? vmem_rd_ff.phase : 16'd0;
   assign b_vib16 = {{4{vib_ff[7]}}, vib_ff, 4'b0000};

   // stage C: sample times modulated gain
   assign c_smp  = signed'(wave_rd_ff[7:2]);
   assign c_gain = signed'({4'b0000, p2_gain_ff}) + signed'({trem_ff[7], trem_ff, 3'b000});
   assign c_prod = 18'(c_smp) * 18'(c_gain);

   // stage D: accumulate
   assign d_sum = sum_ff + (p3_act_ff ? p3_q_ff : 8'd0);
   assign d_dac = pwtm_pkg::DAC_OFFSET + d_sum;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      vib_in       = vib_ff;
      trem_in      = trem_ff;
      st_idx_in    = st_idx_ff;
      st_step_in   = st_step_ff;
      st_gain_in   = st_gain_ff;
      active_in    = active_ff;
      phase_vld_in = phase_vld_ff;
      vmem_re      = 1'b0;
      vmem_raddr   = cnt_ff;
      vmem_we      = 1'b0;
      vmem_waddr   = p1_idx_ff;
      vmem_wdata   = '{phase: b_phase + vmem_rd_ff.step + b_vib16,
                       step: vmem_rd_ff.step, gain: vmem_rd_ff.gain};
      p1_vld_in    = 1'b0;
      p1_last_in   = 1'b0;
      p1_idx_in    = cnt_ff;
      hold_in      = hold_ff;
      out_load     = 1'b0;
      rsp_dac_in   = rsp_dac_ff;
      sum_in       = (p3_vld_ff) ? d_sum : sum_ff;

      // stage B write-back of the advanced phase
      if (b_act) begin
         vmem_we                 = 1'b1;
         phase_vld_in[p1_idx_ff] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (act_code)
                  pwtm_pkg::ACT_TICK: begin
                     vmem_re    = 1'b1;
                     vmem_raddr = '0;
                     p1_vld_in  = 1'b1;
                     p1_idx_in  = '0;
                     p1_last_in = (LAST_VOICE == '0);
                     cnt_in     = VW'(1);
                     vib_in     = req_vibrato_amount;
                     trem_in    = req_tremolo_amount;
                     sum_in     = 8'd0;
                     if (LAST_VOICE == '0) begin
                        state_in = ST_DRAIN;
                     end else begin
                        state_in = ST_TICK;
                     end
                  end
                  pwtm_pkg::ACT_START: begin
                     if (vi_ok) begin
                        vmem_re            = 1'b1;
                        vmem_raddr         = vi_addr;
                        active_in[vi_addr] = 1'b1;
                        st_idx_in          = vi_addr;
                        st_step_in         = req_step_value;
                        st_gain_in         = req_gain_value;
                        state_in           = ST_START;
                     end
                  end
                  pwtm_pkg::ACT_STOP: begin
                     if (vi_ok) begin
                        active_in[vi_addr] = 1'b0;
                     end
                  end
                  pwtm_pkg::ACT_WRITE: begin
                     // table write handled by the memory block
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_START: begin
            // keep the phase, replace step and gain
            vmem_we                 = 1'b1;
            vmem_waddr              = st_idx_ff;
            vmem_wdata.phase        = phase_vld_ff[st_idx_ff] ? vmem_rd_ff.phase : 16'd0;
            vmem_wdata.step         = st_step_ff;
            vmem_wdata.gain         = st_gain_ff;
            phase_vld_in[st_idx_ff] = 1'b1;
            state_in                = ST_IDLE;
         end
         ST_TICK: begin
            vmem_re    = 1'b1;
            vmem_raddr = cnt_ff;
            p1_vld_in  = 1'b1;
            p1_idx_in  = cnt_ff;
            p1_last_in = (cnt_ff == LAST_VOICE);
            cnt_in     = cnt_ff + VW'(1);
            if (cnt_ff == LAST_VOICE) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (p3_vld_ff && p3_last_ff) begin
               if (slot_free) begin
                  out_load   = 1'b1;
                  rsp_dac_in = d_dac;
                  state_in   = ST_IDLE;
               end else begin
                  hold_in  = d_dac;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               out_load   = 1'b1;
               rsp_dac_in = hold_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign wave_re    = p1_vld_ff;
   assign wave_raddr = b_phase[15:8];

   always_comb begin
      p2_vld_in  = p1_vld_ff;
      p2_last_in = p1_last_ff;
      p2_act_in  = b_act;
      p2_gain_in = vmem_rd_ff.gain;
      p3_vld_in  = p2_vld_ff;
      p3_last_in = p2_last_ff;
      p3_act_in  = p2_act_ff;
      p3_q_in    = c_prod[14:7];
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // voice memory
   always_ff @(posedge clock) begin
      if (vmem_we) begin
         vmem[vmem_waddr] <= vmem_wdata;
      end
      if (vmem_re) begin
         vmem_rd_ff <= vmem[vmem_raddr];
      end
   end

   // wavetable memory
   always_ff @(posedge clock) begin
      if (req_acc && (act_code == pwtm_pkg::ACT_WRITE)) begin
         wave_mem[req_table_index] <= req_table_value;
      end
      if (wave_re) begin
         wave_rd_ff <= wave_mem[wave_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         active_ff    <= '0;
         phase_vld_ff <= '0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         p3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         phase_vld_ff <= phase_vld_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         p3_vld_ff    <= p3_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vib_ff     <= vib_in;
      trem_ff    <= trem_in;
      st_idx_ff  <= st_idx_in;
      st_step_ff <= st_step_in;
      st_gain_ff <= st_gain_in;
      p1_last_ff <= p1_last_in;
      p1_idx_ff  <= p1_idx_in;
      p2_last_ff <= p2_last_in;
      p2_act_ff  <= p2_act_in;
      p2_gain_ff <= p2_gain_in;
      p3_last_ff <= p3_last_in;
      p3_act_ff  <= p3_act_in;
      p3_q_ff    <= p3_q_in;
      sum_ff     <= sum_in;
      hold_ff    <= hold_in;
      rsp_dac_ff <= rsp_dac_in;
   end

   `PWTM_ASSERT_IMP(a_no_rw_same_voice, vmem_we && vmem_re, vmem_waddr != vmem_raddr,
                    "voice memory read and write hit the same entry")
   `PWTM_ASSERT_NXT(a_start_writes_back,
                    req_acc && (act_code == pwtm_pkg::ACT_START) && vi_ok,
                    vmem_we && (vmem_waddr == st_idx_ff),
                    "start did not write the voice entry")
   `PWTM_ASSERT_IMP(a_last_in_drain, p3_vld_ff && p3_last_ff, state_ff == ST_DRAIN,
                    "last voice left the pipeline outside drain")
   `PWTM_ASSERT_IMP(a_rsp_from_tick, $rose(rsp_valid_ff),
                    $past(p3_vld_ff && p3_last_ff) || $past(state_ff == ST_HOLD),
                    "result appeared without a finished tick")

endmodule
